@@ rtl/olis_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the ordered list block.
package olis_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int OP_W      = 2;
	localparam int POS_W     = 5;
	localparam int VAL_W     = 32;
	localparam int STAT_W    = 3;
	localparam int FIDX_W    = 4;
	localparam int ECNT_W    = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_SRCH
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 kind;
		logic [POS_W-1:0]         pos;
		logic signed [VAL_W-1:0]  value;
	} cell_cmd_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} state_t;

endpackage

@@ rtl/olis_if.sv @@
`timescale 1ns / 1ps
// Interfaces: request and response channels of the ordered list block.
interface olis_req_if import olis_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [POS_W-1:0]         position;
	logic signed [VAL_W-1:0]  value;

	modport source (output valid, operation, position, value, input ready);
	modport sink (input valid, operation, position, value, output ready);
endinterface

interface olis_rsp_if import olis_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [FIDX_W-1:0]  found_index;
	logic [ECNT_W-1:0]  entry_count;

	modport source (output valid, status, found_index, entry_count, input ready);
	modport sink (input valid, status, found_index, entry_count, output ready);
endinterface

@@ rtl/olis_cell.sv @@
`timescale 1ns / 1ps
// Cell: one list entry with shift-up, shift-down and compare logic.
module olis_cell import olis_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_cmd_t                cmd,
	input  logic                     live,
	input  logic signed [VAL_W-1:0]  left_data,
	input  logic signed [VAL_W-1:0]  right_data,
	output logic signed [VAL_W-1:0]  data,
	output logic                     match
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CMPW-1:0]          idx_c;
	logic [CMPW-1:0]          pos_c;
	logic signed [VAL_W-1:0]  data_q;
	logic                     match_q;

	assign idx_c = CMPW'(INDEX);
	assign pos_c = CMPW'(cmd.pos);

	always_ff @(posedge clk) begin
		case (cmd.kind)
			CELL_INS: begin
				if (idx_c == pos_c) begin
					data_q <= cmd.value;
				end else if (idx_c > pos_c) begin
					data_q <= left_data;
				end
			end
			CELL_DEL: begin
				if (idx_c >= pos_c) begin
					data_q <= right_data;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.kind == CELL_SRCH) begin
			match_q <= live && (data_q == cmd.value);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

@@ rtl/ordered_list_insert_delete_search.sv @@
`timescale 1ns / 1ps
// Top level: ordered list of signed words built from a chain of entry cells.
//
// channel | dir | fields
// req     | in  | operation, position, value
// rsp     | out | status, found_index, entry_count
//
// Insert and delete shift all cells at once; unused codes answer with a bad-position status.
// Search works in two steps: the cells latch their compare bits, then a scan pointer
// walks them one a cycle from entry zero until a match or the last live entry.
// Reset clears the count and the controller; entry contents stay undefined.
// A request waits while a search scans or an unread response holds the output.
module ordered_list_insert_delete_search import olis_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	olis_req_if.sink   req,
	olis_rsp_if.source rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_t                   state_q, state_nxt;
	logic [CW-1:0]            count_q;
	logic [IW-1:0]            idx_q;
	logic                     rsp_valid_q;
	status_t                  status_q;
	logic [FIDX_W-1:0]        found_q;
	logic [ECNT_W-1:0]        ecnt_q;

	cell_cmd_t                cmd;
	logic [DEPTH-1:0]         live;
	logic [DEPTH-1:0]         match;
	logic signed [VAL_W-1:0]  cell_data [DEPTH];

	logic                     acc;
	logic [CMPW-1:0]          pos_c;
	logic [CMPW-1:0]          cnt_c;
	logic                     full;
	logic                     empty;
	logic                     ins_ok;
	logic                     del_ok;
	logic                     hit;
	logic                     last;
	logic                     load_res;
	status_t                  res_status;
	logic [CW-1:0]            res_count;
	logic [FIDX_W-1:0]        res_found;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [VAL_W-1:0] left_d;
			logic signed [VAL_W-1:0] right_d;
			if (gi == 0) begin : g_first
				assign left_d = cell_data[gi];
			end else begin : g_left
				assign left_d = cell_data[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_d = cell_data[gi];
			end else begin : g_right
				assign right_d = cell_data[gi+1];
			end
			assign live[gi] = CW'(gi) < count_q;
			olis_cell #(
				.DEPTH (DEPTH),
				.INDEX (gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.cmd        (cmd),
				.live       (live[gi]),
				.left_data  (left_d),
				.right_data (right_d),
				.data       (cell_data[gi]),
				.match      (match[gi])
			);
		end
	endgenerate

	assign acc    = req.valid && req.ready;
	assign pos_c  = CMPW'(req.position);
	assign cnt_c  = CMPW'(count_q);
	assign full   = count_q == CW'(DEPTH);
	assign empty  = count_q == '0;
	assign ins_ok = (pos_c <= cnt_c) && !full;
	assign del_ok = !empty && (pos_c < cnt_c);
	assign hit    = match[idx_q];
	assign last   = CW'(idx_q) == (count_q - CW'(1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc && (op_t'(req.operation) == OP_SEARCH) && !empty) begin
					state_nxt = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				if (hit || last) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		req.ready  = (state_q == FSM_IDLE) && (!rsp_valid_q || rsp.ready);
		cmd.kind   = CELL_HOLD;
		cmd.pos    = req.position;
		cmd.value  = req.value;
		load_res   = 1'b0;
		res_status = ST_OK;
		res_found  = '0;
		res_count  = count_q;
		case (state_q)
			FSM_IDLE: begin
				if (acc) begin
					case (op_t'(req.operation))
						OP_INSERT: begin
							load_res = 1'b1;
							if (pos_c > cnt_c) begin
								res_status = ST_BAD_POS;
							end else if (full) begin
								res_status = ST_FULL;
							end else begin
								cmd.kind  = CELL_INS;
								res_count = count_q + CW'(1);
							end
						end
						OP_DELETE: begin
							load_res = 1'b1;
							if (empty) begin
								res_status = ST_EMPTY;
							end else if (pos_c >= cnt_c) begin
								res_status = ST_BAD_POS;
							end else begin
								cmd.kind  = CELL_DEL;
								res_count = count_q - CW'(1);
							end
						end
						OP_SEARCH: begin
							cmd.kind = CELL_SRCH;
							if (empty) begin
								load_res   = 1'b1;
								res_status = ST_NOT_FOUND;
							end
						end
						default: begin
							load_res   = 1'b1;
							res_status = ST_BAD_POS;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				if (hit) begin
					load_res  = 1'b1;
					res_found = FIDX_W'(idx_q);
				end else if (last) begin
					load_res   = 1'b1;
					res_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == FSM_SCAN) begin
				idx_q <= idx_q + IW'(1);
			end else begin
				idx_q <= '0;
			end
			count_q <= res_count;
			if (load_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			status_q <= res_status;
			found_q  <= res_found;
			ecnt_q   <= ECNT_W'(res_count);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_index = found_q;
	assign rsp.entry_count = ecnt_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	a_scan_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN) |-> !rsp_valid_q)
		else $error("response pending during search scan");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN) |-> (CW'(idx_q) < count_q))
		else $error("scan pointer beyond last entry");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op_t'(req.operation) == OP_INSERT) && ins_ok)
			|=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op_t'(req.operation) == OP_DELETE) && del_ok)
			|=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not shrink the list");
`endif

endmodule
